@@ src/nfcfes_pkg.sv @@
package nfcfes_pkg;

  // Bytes moved by one FIFO unload, and the most moved by one load outside authentication
  localparam int CHUNK_BYTES = 32;

  // Results one item can cause, and result queue depth
  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Request types
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_STATUS = 1'b1;

  // Interrupt flag bit positions
  localparam int IRQ_TIMER = 0;
  localparam int IRQ_LO    = 2;
  localparam int IRQ_HI    = 3;
  localparam int IRQ_IDLE  = 4;
  localparam int IRQ_RX    = 5;
  localparam int IRQ_TX    = 6;

  // Largest received bit count
  localparam logic [10:0] BITS_MAX = 11'h7FF;

  typedef enum logic [1:0] {
    CMD_AUTH   = 2'd0,
    CMD_TX     = 2'd1,
    CMD_TRX    = 2'd2,
    CMD_OTHER  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_UNLOAD = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  chunk_count;
    logic [7:0]  send_offset;
    logic [7:0]  receive_offset;
    logic        finish_status;
    logic [10:0] received_bits;
    logic        last_result;
  } result_t;

  // Results written into the queue in one cycle
  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MAX_RESULTS-1:0]    res;
  } push_t;

  // Saturating 8-bit add
  function automatic logic [7:0] sat_add8(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

@@ src/nfcfes_if.sv @@
interface nfcfes_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] command_kind;
  logic [7:0] send_length;
  logic [6:0] irq_flags;
  logic [6:0] fifo_level;
  logic [2:0] valid_last_bits;

  modport source (
    output valid, req_type, command_kind, send_length, irq_flags, fifo_level,
           valid_last_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, command_kind, send_length, irq_flags, fifo_level,
           valid_last_bits,
    output ready
  );
endinterface

interface nfcfes_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  chunk_count;
  logic [7:0]  send_offset;
  logic [7:0]  receive_offset;
  logic        finish_status;
  logic [10:0] received_bits;
  logic        last_result;

  modport source (
    output valid, action, chunk_count, send_offset, receive_offset, finish_status,
           received_bits, last_result,
    input  ready
  );
  modport sink (
    input  valid, action, chunk_count, send_offset, receive_offset, finish_status,
           received_bits, last_result,
    output ready
  );
endinterface

@@ src/nfcfes_queue.sv @@
module nfcfes_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nfcfes_pkg::push_t    push_i,
  output logic                 room_o,
  nfcfes_rsp_if.source         out_o
);

  nfcfes_pkg::result_t               mem_q [nfcfes_pkg::QDEPTH];
  logic [nfcfes_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [nfcfes_pkg::QCNT_W-1:0]     cnt_q, cnt_d, cnt_after;
  logic                              pop;
  nfcfes_pkg::result_t               head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = mem_q[rd_q];

  // Room for a full set of results once this cycle's word leaves
  assign cnt_after = cnt_q - nfcfes_pkg::QCNT_W'(pop);
  assign room_o    = cnt_after <=
                     nfcfes_pkg::QCNT_W'(nfcfes_pkg::QDEPTH - nfcfes_pkg::MAX_RESULTS);

  // Output word
  assign out_o.valid          = cnt_q != '0;
  assign out_o.action         = head.action;
  assign out_o.chunk_count    = head.chunk_count;
  assign out_o.send_offset    = head.send_offset;
  assign out_o.receive_offset = head.receive_offset;
  assign out_o.finish_status  = head.finish_status;
  assign out_o.received_bits  = head.received_bits;
  assign out_o.last_result    = head.last_result;

  // Pointers and fill count
  always_comb begin
    wr_d  = wr_q + nfcfes_pkg::QPTR_W'(push_i.cnt);
    rd_d  = rd_q + nfcfes_pkg::QPTR_W'(pop);
    cnt_d = cnt_after + nfcfes_pkg::QCNT_W'(push_i.cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage: up to three consecutive entries per cycle
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < nfcfes_pkg::MAX_RESULTS; k++) begin
      if (2'(k) < push_i.cnt) begin
        mem_q[wr_q + nfcfes_pkg::QPTR_W'(k)] <= push_i.res[k];
      end
    end
  end

endmodule

@@ src/nfc_frame_exchange_sequencer.sv @@
// An accepted word waits in the input stage until the result queue has room for a full
//   set of results; it is then decided and its results written into the queue.
// Throughput: one input word per cycle while each causes one result and the output
//   is ready; one result leaves per ready cycle, set by the queue's single read port.
// Reset: asynchronous, active low; clears the exchange state, the input stage and queue.
module nfc_frame_exchange_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  nfcfes_req_if.sink    in_i,
  nfcfes_rsp_if.source  out_o
);

  typedef struct packed {
    logic       active;
    logic [1:0] cmd;
    logic [7:0] rem;
    logic [7:0] off;
    logic [7:0] rcv;
  } state_t;

  state_t            st_q, st_d;
  logic              s1_valid_q;
  logic              s1_req_q;
  logic [1:0]        s1_kind_q;
  logic [7:0]        s1_slen_q;
  logic [6:0]        s1_irq_q;
  logic [6:0]        s1_level_q;
  logic [2:0]        s1_lastb_q;
  logic              room, s1_fire;
  nfcfes_pkg::push_t push;

  // Decision logic signals
  logic        timer, do_load, do_unload, do_finish;
  logic [7:0]  chunk, rem_after, rcv_unl;
  logic [6:0]  drain;
  logic [8:0]  total;
  logic [11:0] bits_raw;
  logic [10:0] bits;
  nfcfes_pkg::result_t r_load, r_unload, r_finish, r_none;
  logic [1:0]  n;

  assign s1_fire  = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || s1_fire;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_req_q   <= in_i.req_type;
      s1_kind_q  <= in_i.command_kind;
      s1_slen_q  <= in_i.send_length;
      s1_irq_q   <= in_i.irq_flags;
      s1_level_q <= in_i.fifo_level;
      s1_lastb_q <= in_i.valid_last_bits;
    end
  end

  // Status decisions: load, then unload, then finish
  always_comb begin
    timer     = s1_irq_q[nfcfes_pkg::IRQ_TIMER];
    chunk     = (st_q.rem < 8'(nfcfes_pkg::CHUNK_BYTES)) ? st_q.rem
                                                         : 8'(nfcfes_pkg::CHUNK_BYTES);
    do_load   = !timer && (st_q.cmd == nfcfes_pkg::CMD_TX || st_q.cmd == nfcfes_pkg::CMD_TRX)
                && s1_irq_q[nfcfes_pkg::IRQ_LO] && st_q.rem != '0;
    rem_after = do_load ? st_q.rem - chunk : st_q.rem;
    do_unload = !timer && st_q.cmd == nfcfes_pkg::CMD_TRX
                && s1_irq_q[nfcfes_pkg::IRQ_HI] && s1_irq_q[nfcfes_pkg::IRQ_TX]
                && rem_after == '0 && s1_level_q > 7'(nfcfes_pkg::CHUNK_BYTES);
    case (st_q.cmd)
      nfcfes_pkg::CMD_AUTH: do_finish = timer || s1_irq_q[nfcfes_pkg::IRQ_IDLE];
      nfcfes_pkg::CMD_TX:   do_finish = timer || (s1_irq_q[nfcfes_pkg::IRQ_TX] &&
                                                  rem_after == '0);
      nfcfes_pkg::CMD_TRX:  do_finish = timer || (s1_irq_q[nfcfes_pkg::IRQ_RX] &&
                                                  rem_after == '0);
      default:              do_finish = timer;
    endcase

    // Receive accounting for a transceive finish
    rcv_unl  = do_unload ? nfcfes_pkg::sat_add8(st_q.rcv, 8'(nfcfes_pkg::CHUNK_BYTES))
                         : st_q.rcv;
    drain    = do_unload ? s1_level_q - 7'(nfcfes_pkg::CHUNK_BYTES) : s1_level_q;
    total    = {1'b0, rcv_unl} + {2'b00, drain};
    if (s1_lastb_q != '0) begin
      bits_raw = (total == '0) ? 12'd0 : {total - 9'd1, s1_lastb_q};
    end else begin
      bits_raw = {total, 3'b000};
    end
    bits = (bits_raw > {1'b0, nfcfes_pkg::BITS_MAX}) ? nfcfes_pkg::BITS_MAX
                                                     : bits_raw[10:0];
  end

  // Result words and next state
  always_comb begin
    r_none   = '{action: nfcfes_pkg::ACT_NONE, default: '0};
    r_load   = r_none;
    r_unload = r_none;
    r_finish = r_none;
    st_d     = st_q;
    push.cnt = 2'd0;
    push.res = '0;
    n        = 2'd0;

    if (s1_req_q == nfcfes_pkg::REQ_START) begin
      st_d.active = 1'b1;
      st_d.cmd    = s1_kind_q;
      st_d.rcv    = '0;
      if (s1_kind_q == nfcfes_pkg::CMD_AUTH) begin
        r_load.action      = nfcfes_pkg::ACT_LOAD;
        r_load.chunk_count = s1_slen_q;
        st_d.rem           = '0;
        st_d.off           = s1_slen_q;
        push.res[0]        = r_load;
      end else begin
        st_d.rem    = s1_slen_q;
        st_d.off    = '0;
        push.res[0] = r_none;
      end
      n = 2'd1;
    end else if (!st_q.active) begin
      push.res[0] = r_none;
      n           = 2'd1;
    end else begin
      r_load.action      = nfcfes_pkg::ACT_LOAD;
      r_load.chunk_count = chunk;
      r_load.send_offset = st_q.off;
      r_unload.action         = nfcfes_pkg::ACT_UNLOAD;
      r_unload.chunk_count    = 8'(nfcfes_pkg::CHUNK_BYTES);
      r_unload.receive_offset = st_q.rcv;
      r_finish.action        = nfcfes_pkg::ACT_FINISH;
      r_finish.finish_status = timer;
      if (st_q.cmd == nfcfes_pkg::CMD_TRX) begin
        r_finish.chunk_count    = {1'b0, drain};
        r_finish.receive_offset = rcv_unl;
        r_finish.received_bits  = bits;
      end

      if (do_load) begin
        st_d.rem = rem_after;
        st_d.off = st_q.off + chunk;
        push.res[n] = r_load;
        n = n + 2'd1;
      end
      if (do_unload) begin
        st_d.rcv = rcv_unl;
        push.res[n] = r_unload;
        n = n + 2'd1;
      end
      if (do_finish) begin
        st_d.active = 1'b0;
        if (st_q.cmd == nfcfes_pkg::CMD_TRX) begin
          st_d.rcv = nfcfes_pkg::sat_add8(rcv_unl, {1'b0, drain});
        end
        push.res[n] = r_finish;
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        push.res[0] = r_none;
        n = 2'd1;
      end
    end

    // Mark the final result of this word
    push.res[n - 2'd1].last_result = 1'b1;
    if (s1_fire) begin
      push.cnt = n;
    end else begin
      st_d = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  nfcfes_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

  // Every decided word leaves a result waiting
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_o.valid)
    else $error("decided word left no result");

  // A decided word pushes one to three results
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> push.cnt != 2'd0)
    else $error("decided word pushed no result");

  // Exactly one pushed result carries the last mark
  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> $countones({push.res[2].last_result && push.cnt == 2'd3,
                            push.res[1].last_result && push.cnt >= 2'd2,
                            push.res[0].last_result}) == 1)
    else $error("last mark not unique");

  // A finish always ends the exchange
  a_finish_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_req_q == nfcfes_pkg::REQ_STATUS && st_q.active && do_finish)
      |=> !st_q.active)
    else $error("exchange still active after finish");

endmodule
